>>> sv/qrs_pkg.sv
`timescale 1ns / 1ps
package qrs_pkg;

   // result classification codes
   localparam logic [1:0] STATUS_NONE   = 2'd0;
   localparam logic [1:0] STATUS_ONE    = 2'd1;
   localparam logic [1:0] STATUS_TWO    = 2'd2;
   localparam logic [1:0] STATUS_ZERO_A = 2'd3;

   localparam int COEF_W      = 16;
   localparam int DISC_W      = 34;
   localparam int RAD_W       = 64;
   localparam int ROOT_W      = 32;
   localparam int SQ_REM_W    = 35;
   localparam int SQRT_STAGES = RAD_W / 2;
   localparam int NUM_W       = 34;
   localparam int DIV_STAGES  = NUM_W;
   localparam int DEN_W       = 16;
   localparam int DV_REM_W    = DEN_W + 1;
   localparam int QUO_W       = NUM_W + 1;
   localparam int OUT_W       = 32;

   // side information carried along the pipeline with each transaction
   typedef struct packed {
      logic                     valid;
      logic [1:0]               status;
      logic signed [DISC_W-1:0] disc;
      logic signed [COEF_W-1:0] coef_a;
      logic signed [COEF_W-1:0] coef_b;
   } qrs_info_type;

endpackage

>>> sv/qrs_if.sv
`timescale 1ns / 1ps
interface qrs_req_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [qrs_pkg::COEF_W-1:0]         coef_a;
   logic signed [qrs_pkg::COEF_W-1:0]         coef_b;
   logic signed [qrs_pkg::COEF_W-1:0]         coef_c;
   modport source (output valid, coef_a, coef_b, coef_c, input ready);
   modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic [1:0]                                root_status;
   logic signed [qrs_pkg::DISC_W-1:0]         discriminant;
   logic signed [qrs_pkg::OUT_W-1:0]          root_plus;
   logic signed [qrs_pkg::OUT_W-1:0]          root_minus;
   logic                                      saturated;
   modport source (output valid, root_status, discriminant, root_plus, root_minus,
                   saturated, input ready);
   modport sink   (input valid, root_status, discriminant, root_plus, root_minus,
                   saturated, output ready);
endinterface

>>> sv/qrs_disc.sv
`timescale 1ns / 1ps
module qrs_disc (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic signed [qrs_pkg::COEF_W-1:0]  coef_a,
   input  logic signed [qrs_pkg::COEF_W-1:0]  coef_b,
   input  logic signed [qrs_pkg::COEF_W-1:0]  coef_c,
   output qrs_pkg::qrs_info_type              out_info
);

   logic                                      v1_ff;
   logic signed [2*qrs_pkg::COEF_W-1:0]       bb_ff;
   logic signed [2*qrs_pkg::COEF_W-1:0]       ac_ff;
   logic signed [qrs_pkg::COEF_W-1:0]         a1_ff;
   logic signed [qrs_pkg::COEF_W-1:0]         b1_ff;
   logic signed [qrs_pkg::DISC_W-1:0]         disc_in;
   qrs_pkg::qrs_info_type                     info_in;
   qrs_pkg::qrs_info_type                     info_ff;

   // stage 1: the two products
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
      if (en) begin
         bb_ff <= coef_b * coef_b;
         ac_ff <= coef_a * coef_c;
         a1_ff <= coef_a;
         b1_ff <= coef_b;
      end
   end

   // stage 2: b*b - 4ac and classification
   always_comb begin
      disc_in = {{2{bb_ff[31]}}, bb_ff}
              - ({{2{ac_ff[31]}}, ac_ff} <<< 2);
      info_in.valid  = v1_ff;
      info_in.disc   = disc_in;
      info_in.coef_a = a1_ff;
      info_in.coef_b = b1_ff;
      if (a1_ff == '0) begin
         info_in.status = qrs_pkg::STATUS_ZERO_A;
      end else if (disc_in < 0) begin
         info_in.status = qrs_pkg::STATUS_NONE;
      end else if (disc_in == '0) begin
         info_in.status = qrs_pkg::STATUS_ONE;
      end else begin
         info_in.status = qrs_pkg::STATUS_TWO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         info_ff.valid <= 1'b0;
      end else if (en) begin
         info_ff.valid <= info_in.valid;
      end
      if (en) begin
         info_ff.status <= info_in.status;
         info_ff.disc   <= info_in.disc;
         info_ff.coef_a <= info_in.coef_a;
         info_ff.coef_b <= info_in.coef_b;
      end
   end

   assign out_info = info_ff;

endmodule

>>> sv/qrs_sqrt.sv
`timescale 1ns / 1ps
module qrs_sqrt (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  qrs_pkg::qrs_info_type              in_info,
   output qrs_pkg::qrs_info_type              out_info,
   output logic [qrs_pkg::ROOT_W-1:0]         out_root
);

   localparam int N = qrs_pkg::SQRT_STAGES;

   logic [qrs_pkg::RAD_W-1:0]     rad_src  [0:N-1];
   logic [qrs_pkg::SQ_REM_W-1:0]  rem_src  [0:N-1];
   logic [qrs_pkg::ROOT_W-1:0]    root_src [0:N-1];
   qrs_pkg::qrs_info_type         info_src [0:N-1];
   logic [qrs_pkg::RAD_W-1:0]     rad_ff   [0:N-1];
   logic [qrs_pkg::SQ_REM_W-1:0]  rem_ff   [0:N-1];
   logic [qrs_pkg::ROOT_W-1:0]    root_ff  [0:N-1];
   qrs_pkg::qrs_info_type         info_ff  [0:N-1];
   logic                          take;

   // radicand d * 2^30, only for a real, solvable equation
   assign take = (in_info.status == qrs_pkg::STATUS_ONE)
              || (in_info.status == qrs_pkg::STATUS_TWO);

   // one result bit per stage, two radicand bits consumed per stage
   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [qrs_pkg::SQ_REM_W-1:0] cand;
      logic [qrs_pkg::SQ_REM_W-1:0] trial;
      logic                         ge;

      if (k == 0) begin : g_first
         assign rad_src[k]  = take ? {1'b0, in_info.disc[32:0], 30'd0} : '0;
         assign rem_src[k]  = '0;
         assign root_src[k] = '0;
         assign info_src[k] = in_info;
      end else begin : g_next
         assign rad_src[k]  = rad_ff[k-1];
         assign rem_src[k]  = rem_ff[k-1];
         assign root_src[k] = root_ff[k-1];
         assign info_src[k] = info_ff[k-1];
      end

      assign cand  = {rem_src[k][qrs_pkg::SQ_REM_W-3:0],
                      rad_src[k][qrs_pkg::RAD_W-1 -: 2]};
      assign trial = {1'b0, root_src[k], 2'b01};
      assign ge    = (cand >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            info_ff[k].valid <= 1'b0;
         end else if (en) begin
            info_ff[k].valid <= info_src[k].valid;
         end
         if (en) begin
            info_ff[k].status <= info_src[k].status;
            info_ff[k].disc   <= info_src[k].disc;
            info_ff[k].coef_a <= info_src[k].coef_a;
            info_ff[k].coef_b <= info_src[k].coef_b;
            rad_ff[k]  <= rad_src[k] << 2;
            rem_ff[k]  <= ge ? (cand - trial) : cand;
            root_ff[k] <= {root_src[k][qrs_pkg::ROOT_W-2:0], ge};
         end
      end
   end

   assign out_info = info_ff[N-1];
   assign out_root = root_ff[N-1];

endmodule

>>> sv/qrs_div.sv
`timescale 1ns / 1ps
module qrs_div (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [qrs_pkg::NUM_W-1:0]   num,
   input  logic signed [qrs_pkg::DEN_W-1:0]   den,
   output logic signed [qrs_pkg::QUO_W-1:0]   quo
);

   localparam int N = qrs_pkg::DIV_STAGES;

   logic [qrs_pkg::NUM_W-1:0]     num_src [0:N-1];
   logic [qrs_pkg::DV_REM_W-1:0]  rem_src [0:N-1];
   logic [qrs_pkg::NUM_W-1:0]     quo_src [0:N-1];
   logic [qrs_pkg::DEN_W-1:0]     den_src [0:N-1];
   logic                          neg_src [0:N-1];
   logic [qrs_pkg::NUM_W-1:0]     num_ff  [0:N-1];
   logic [qrs_pkg::DV_REM_W-1:0]  rem_ff  [0:N-1];
   logic [qrs_pkg::NUM_W-1:0]     quo_ff  [0:N-1];
   logic [qrs_pkg::DEN_W-1:0]     den_ff  [0:N-1];
   logic                          neg_ff  [0:N-1];
   logic [qrs_pkg::NUM_W-1:0]     num_mag;
   logic [qrs_pkg::DEN_W-1:0]     den_mag;

   // divide magnitudes, restore the sign at the end (truncates toward zero)
   assign num_mag = num[qrs_pkg::NUM_W-1] ? (~num + 1'b1) : num;
   assign den_mag = den[qrs_pkg::DEN_W-1] ? (~den + 1'b1) : den;

   // restoring division, one quotient bit per stage
   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [qrs_pkg::DV_REM_W-1:0] cand;
      logic                         ge;

      if (k == 0) begin : g_first
         assign num_src[k] = num_mag;
         assign rem_src[k] = '0;
         assign quo_src[k] = '0;
         assign den_src[k] = den_mag;
         assign neg_src[k] = num[qrs_pkg::NUM_W-1] ^ den[qrs_pkg::DEN_W-1];
      end else begin : g_next
         assign num_src[k] = num_ff[k-1];
         assign rem_src[k] = rem_ff[k-1];
         assign quo_src[k] = quo_ff[k-1];
         assign den_src[k] = den_ff[k-1];
         assign neg_src[k] = neg_ff[k-1];
      end

      assign cand = {rem_src[k][qrs_pkg::DV_REM_W-2:0], num_src[k][qrs_pkg::NUM_W-1]};
      assign ge   = (cand >= {1'b0, den_src[k]});

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[k] <= num_src[k] << 1;
            rem_ff[k] <= ge ? (cand - {1'b0, den_src[k]}) : cand;
            quo_ff[k] <= {quo_src[k][qrs_pkg::NUM_W-2:0], ge};
            den_ff[k] <= den_src[k];
            neg_ff[k] <= neg_src[k];
         end
      end
   end

   assign quo = neg_ff[N-1] ? -$signed({1'b0, quo_ff[N-1]})
                            :  $signed({1'b0, quo_ff[N-1]});

endmodule

>>> sv/quadratic_root_solver.sv
`timescale 1ns / 1ps
// Real roots of a*x^2 + b*x + c = 0 from signed Q8.8 coefficients. Each transaction
// yields one result: the exact discriminant b*b - 4ac in Q16.16, a status (no real
// roots, one root, two roots, a is zero) and the roots (-b +/- sqrt(d)) / (2a) in
// Q16.16, truncated toward zero and clipped to the 32-bit range with a flag. The
// pipeline takes a transaction every cycle unless a result waits. A result passes 70
// register stages: two for the discriminant (products, then subtraction and
// classification), 32 for the square root (one result bit per stage), one to form the
// numerators, 34 for the division (one quotient bit per stage) and the output register.
// The whole pipeline holds while a result waits.
module quadratic_root_solver (
   input  logic        clock,
   input  logic        reset,
   qrs_req_if.sink     req,
   qrs_rsp_if.source   rsp
);

   localparam int ND = qrs_pkg::DIV_STAGES;

   logic                                   en;
   qrs_pkg::qrs_info_type                  disc_info;
   qrs_pkg::qrs_info_type                  sq_info;
   logic [qrs_pkg::ROOT_W-1:0]             sq_root;
   logic signed [qrs_pkg::NUM_W-1:0]       base;
   logic signed [qrs_pkg::NUM_W-1:0]       nplus_ff;
   logic signed [qrs_pkg::NUM_W-1:0]       nminus_ff;
   qrs_pkg::qrs_info_type                  num_info_ff;
   qrs_pkg::qrs_info_type                  dl_src [0:ND-1];
   qrs_pkg::qrs_info_type                  dl_ff  [0:ND-1];
   qrs_pkg::qrs_info_type                  fin;
   logic signed [qrs_pkg::QUO_W-1:0]       qplus;
   logic signed [qrs_pkg::QUO_W-1:0]       qminus;
   logic signed [qrs_pkg::OUT_W-1:0]       cplus;
   logic signed [qrs_pkg::OUT_W-1:0]       cminus;
   logic                                   splus;
   logic                                   sminus;
   logic                                   rsp_valid_ff;
   logic [1:0]                             status_ff;
   logic signed [qrs_pkg::DISC_W-1:0]      disc_ff;
   logic signed [qrs_pkg::OUT_W-1:0]       rplus_ff;
   logic signed [qrs_pkg::OUT_W-1:0]       rminus_ff;
   logic                                   sat_ff;
   logic [1:0]                             status_in;
   logic signed [qrs_pkg::OUT_W-1:0]       rplus_in;
   logic signed [qrs_pkg::OUT_W-1:0]       rminus_in;
   logic                                   sat_in;

   // whole pipeline advances unless a result is waiting
   assign en        = !rsp_valid_ff || rsp.ready;
   assign req.ready = en;

   qrs_disc u_disc (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req.valid),
      .coef_a   (req.coef_a),
      .coef_b   (req.coef_b),
      .coef_c   (req.coef_c),
      .out_info (disc_info)
   );

   qrs_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_info  (disc_info),
      .out_info (sq_info),
      .out_root (sq_root)
   );

   // numerators -b +/- sqrt(d) in Q.23: -b*2^15 +/- sqrt(d * 2^30) on the raw values
   assign base = -($signed({{(qrs_pkg::NUM_W-qrs_pkg::COEF_W){sq_info.coef_b[15]}},
                             sq_info.coef_b}) <<< 15);

   always_ff @(posedge clock) begin
      if (reset) begin
         num_info_ff.valid <= 1'b0;
      end else if (en) begin
         num_info_ff.valid <= sq_info.valid;
      end
      if (en) begin
         num_info_ff.status <= sq_info.status;
         num_info_ff.disc   <= sq_info.disc;
         num_info_ff.coef_a <= sq_info.coef_a;
         num_info_ff.coef_b <= sq_info.coef_b;
         nplus_ff  <= base + $signed({2'b00, sq_root});
         nminus_ff <= base - $signed({2'b00, sq_root});
      end
   end

   qrs_div u_div_plus (
      .clock (clock),
      .en    (en),
      .num   (nplus_ff),
      .den   (num_info_ff.coef_a),
      .quo   (qplus)
   );

   qrs_div u_div_minus (
      .clock (clock),
      .en    (en),
      .num   (nminus_ff),
      .den   (num_info_ff.coef_a),
      .quo   (qminus)
   );

   // side information delayed alongside the dividers
   for (genvar k = 0; k < ND; k++) begin : g_dly
      if (k == 0) begin : g_first
         assign dl_src[k] = num_info_ff;
      end else begin : g_next
         assign dl_src[k] = dl_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dl_ff[k].valid <= 1'b0;
         end else if (en) begin
            dl_ff[k].valid <= dl_src[k].valid;
         end
         if (en) begin
            dl_ff[k].status <= dl_src[k].status;
            dl_ff[k].disc   <= dl_src[k].disc;
            dl_ff[k].coef_a <= dl_src[k].coef_a;
            dl_ff[k].coef_b <= dl_src[k].coef_b;
         end
      end
   end

   assign fin = dl_ff[ND-1];

   // clip quotients to the Q16.16 range
   always_comb begin
      splus  = 1'b0;
      sminus = 1'b0;
      cplus  = qplus[qrs_pkg::OUT_W-1:0];
      cminus = qminus[qrs_pkg::OUT_W-1:0];
      if (qplus > $signed(35'sh07FFFFFFF)) begin
         cplus = 32'sh7FFFFFFF;
         splus = 1'b1;
      end else if (qplus < -$signed(35'sh080000000)) begin
         cplus = 32'sh80000000;
         splus = 1'b1;
      end
      if (qminus > $signed(35'sh07FFFFFFF)) begin
         cminus = 32'sh7FFFFFFF;
         sminus = 1'b1;
      end else if (qminus < -$signed(35'sh080000000)) begin
         cminus = 32'sh80000000;
         sminus = 1'b1;
      end
   end

   // select the reported roots by status
   always_comb begin
      status_in = fin.status;
      rplus_in  = '0;
      rminus_in = '0;
      sat_in    = 1'b0;
      case (fin.status)
         qrs_pkg::STATUS_ONE: begin
            rplus_in = cplus;
            sat_in   = splus;
         end
         qrs_pkg::STATUS_TWO: begin
            rplus_in  = cplus;
            rminus_in = cminus;
            sat_in    = splus | sminus;
         end
         default: begin
            rplus_in = '0;
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= fin.valid;
      end
      if (en) begin
         status_ff <= status_in;
         disc_ff   <= fin.disc;
         rplus_ff  <= rplus_in;
         rminus_ff <= rminus_in;
         sat_ff    <= sat_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.root_status  = status_ff;
   assign rsp.discriminant = disc_ff;
   assign rsp.root_plus    = rplus_ff;
   assign rsp.root_minus   = rminus_ff;
   assign rsp.saturated    = sat_ff;

   a_no_roots_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == qrs_pkg::STATUS_NONE
                       || status_ff == qrs_pkg::STATUS_ZERO_A)
      |-> rplus_ff == '0 && rminus_ff == '0 && !sat_ff)
      else $error("roots reported without real roots");

   a_one_root: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == qrs_pkg::STATUS_ONE
      |-> disc_ff == '0 && rminus_ff == '0)
      else $error("one-root result inconsistent");

   a_two_roots: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == qrs_pkg::STATUS_TWO |-> disc_ff > 0)
      else $error("two roots with non-positive discriminant");

   a_none_neg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == qrs_pkg::STATUS_NONE |-> disc_ff < 0)
      else $error("no roots with non-negative discriminant");

endmodule
